### sv/graph6_adjacency_decoder_core_macros.svh
// Assertion macros shared by the graph6 decoder checker.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef GRAPH6_ADJACENCY_DECODER_CORE_MACROS_SVH
`define GRAPH6_ADJACENCY_DECODER_CORE_MACROS_SVH

// same-cycle implication
`define G6AD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define G6AD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/g6ad_pkg.sv
// Shared types and constants for the graph6 adjacency decoder.
// No dependencies.
`default_nettype none

package g6ad_pkg;

    localparam int MAX_VERTICES  = 64;
    localparam int HEADER_LENGTH = 10;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_FEED  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [2:0] PH_FIRST    = 3'd0;
    localparam logic [2:0] PH_HEADER   = 3'd1;
    localparam logic [2:0] PH_SIZE     = 3'd2;
    localparam logic [2:0] PH_LONG2    = 3'd3;
    localparam logic [2:0] PH_LONGREST = 3'd4;
    localparam logic [2:0] PH_DATA     = 3'd5;
    localparam logic [2:0] PH_END      = 3'd6;

    localparam logic [2:0] STS_BUSY     = 3'd0;
    localparam logic [2:0] STS_DONE     = 3'd1;
    localparam logic [2:0] STS_EMPTY    = 3'd2;
    localparam logic [2:0] STS_BAD_HEAD = 3'd3;
    localparam logic [2:0] STS_TOO_MANY = 3'd4;
    localparam logic [2:0] STS_NO_NL    = 3'd5;
    localparam logic [2:0] STS_BAD_DATA = 3'd6;

    localparam logic [7:0] CH_END  = 8'd0;
    localparam logic [7:0] CH_NL   = 8'd10;
    localparam logic [7:0] CH_HDR  = 8'd62;
    localparam logic [7:0] CH_LO   = 8'd63;
    localparam logic [7:0] CH_LONG = 8'd126;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] byte_in;
        logic [5:0] row_index;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [6:0]  vertex_total;
        logic [2:0]  edges_added;
        logic [63:0] row_bits;
    } out_beat_t;

    typedef struct packed {
        logic        clear;
        logic        wr_en;
        logic [5:0]  wr_addr;
        logic [63:0] wr_data;
        logic [5:0]  rd_addr;
    } mem_req_t;

endpackage

`default_nettype wire

### sv/g6ad_row_mem.sv
// Adjacency row memory: 64 x 64 bits, one write and one read port, registered read.
// Per-row valid flags give the all-zero state after reset or clear. Uses g6ad_pkg.
`default_nettype none

module g6ad_row_mem (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire g6ad_pkg::mem_req_t req,
    output logic [63:0]             rd_row
);
    import g6ad_pkg::*;

    logic [63:0] mem [64];
    logic [63:0] rd_data_reg;
    logic [63:0] valid_reg;
    logic [63:0] valid_next;
    logic        rd_valid_reg;
    logic        rd_valid_next;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd_data_reg <= mem[req.rd_addr];
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (req.clear)
        begin
            valid_next = '0;
        end
        else if (req.wr_en)
        begin
            valid_next[req.wr_addr] = 1'b1;
        end
        rd_valid_next = valid_reg[req.rd_addr] && !req.clear;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    assign rd_row = rd_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

### sv/g6ad_ctrl.sv
// Parser and edge sequencer: header/count decoding, then per set data bit a
// read-modify-write of both mirror rows. Uses g6ad_pkg; drives the row memory through mem_req.
`default_nettype none

module g6ad_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire g6ad_pkg::in_beat_t  in_data,
    output logic                     res_valid,
    input  wire logic                res_ready,
    output g6ad_pkg::out_beat_t      res,
    output g6ad_pkg::mem_req_t       mem_req,
    input  wire logic [63:0]         rd_row
);
    import g6ad_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_EDGE_A = 3'd2;
    localparam logic [2:0] S_EDGE_B = 3'd3;
    localparam logic [2:0] S_RDROW  = 3'd4;
    localparam logic [2:0] S_PUSH   = 3'd5;

    logic [2:0]  state_reg,     state_next;
    logic [2:0]  phase_reg,     phase_next;
    logic [3:0]  hdr_left_reg,  hdr_left_next;
    logic [1:0]  size_left_reg, size_left_next;
    logic [17:0] count_reg,     count_next;
    logic [6:0]  col_reg,       col_next;
    logic [5:0]  row_reg,       row_next;
    logic [2:0]  err_reg,       err_next;
    logic [5:0]  bits_reg,      bits_next;
    logic [2:0]  bits_left_reg, bits_left_next;
    logic [2:0]  edges_reg,     edges_next;
    logic [63:0] rowbits_reg,   rowbits_next;

    logic [7:0]  c;
    logic [7:0]  c_off;
    logic        c_ok;
    logic [2:0]  eff_phase;
    logic        fin;
    logic [2:0]  fin_code;
    logic        enter;
    logic        adv;
    logic        scan_stop;
    logic        cur_bit;

    assign c         = in_data.byte_in;
    assign c_off     = c - CH_LO;
    assign c_ok      = (c >= CH_LO) && (c <= CH_LONG);
    assign eff_phase = (phase_reg == PH_FIRST && c_ok) ? PH_SIZE : phase_reg;
    assign scan_stop = (bits_left_reg == 3'd0) || ({11'b0, col_reg} >= count_reg);
    assign cur_bit   = bits_reg[3'(bits_left_reg - 3'd1)];

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        hdr_left_next  = hdr_left_reg;
        size_left_next = size_left_reg;
        count_next     = count_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        err_next       = err_reg;
        bits_next      = bits_reg;
        bits_left_next = bits_left_reg;
        edges_next     = edges_reg;
        rowbits_next   = rowbits_reg;
        mem_req        = '0;
        mem_req.rd_addr = row_reg;
        fin            = 1'b0;
        fin_code       = STS_BUSY;
        enter          = 1'b0;
        adv            = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    edges_next   = '0;
                    rowbits_next = '0;
                    state_next   = S_PUSH;
                    case (in_data.opcode)
                        OP_START:
                        begin
                            phase_next     = PH_FIRST;
                            hdr_left_next  = '0;
                            size_left_next = '0;
                            count_next     = '0;
                            col_next       = 7'd1;
                            row_next       = '0;
                            err_next       = STS_BUSY;
                            mem_req.clear  = 1'b1;
                        end
                        OP_FEED:
                        begin
                            case (eff_phase)
                                PH_FIRST:
                                begin
                                    if (c == CH_END)
                                    begin
                                        fin = 1'b1; fin_code = STS_EMPTY;
                                    end
                                    else if (c == CH_HDR)
                                    begin
                                        hdr_left_next = 4'(HEADER_LENGTH - 1);
                                        phase_next = (HEADER_LENGTH - 1 != 0) ? PH_HEADER
                                                                              : PH_SIZE;
                                    end
                                    else
                                    begin
                                        fin = 1'b1; fin_code = STS_BAD_HEAD;
                                    end
                                end
                                PH_HEADER:
                                begin
                                    if (c == CH_END)
                                    begin
                                        fin = 1'b1; fin_code = STS_NO_NL;
                                    end
                                    else
                                    begin
                                        hdr_left_next = hdr_left_reg - 4'd1;
                                        if (hdr_left_reg == 4'd1)
                                        begin
                                            phase_next = PH_SIZE;
                                        end
                                    end
                                end
                                PH_SIZE:
                                begin
                                    if (c == CH_END)
                                    begin
                                        fin = 1'b1; fin_code = STS_NO_NL;
                                    end
                                    else if (!c_ok)
                                    begin
                                        fin = 1'b1; fin_code = STS_BAD_HEAD;
                                    end
                                    else if (c == CH_LONG)
                                    begin
                                        count_next = '0;
                                        phase_next = PH_LONG2;
                                    end
                                    else
                                    begin
                                        count_next = {12'b0, c_off[5:0]};
                                        enter      = 1'b1;
                                    end
                                end
                                PH_LONG2:
                                begin
                                    if (c == CH_END)
                                    begin
                                        fin = 1'b1; fin_code = STS_NO_NL;
                                    end
                                    else if (c == CH_LONG)
                                    begin
                                        fin = 1'b1; fin_code = STS_TOO_MANY;
                                    end
                                    else if (!c_ok)
                                    begin
                                        fin = 1'b1; fin_code = STS_BAD_HEAD;
                                    end
                                    else
                                    begin
                                        count_next     = {12'b0, c_off[5:0]};
                                        size_left_next = 2'd2;
                                        phase_next     = PH_LONGREST;
                                    end
                                end
                                PH_LONGREST:
                                begin
                                    if (c == CH_END)
                                    begin
                                        fin = 1'b1; fin_code = STS_NO_NL;
                                    end
                                    else if (!c_ok)
                                    begin
                                        fin = 1'b1; fin_code = STS_BAD_HEAD;
                                    end
                                    else
                                    begin
                                        count_next     = {count_reg[11:0], c_off[5:0]};
                                        size_left_next = size_left_reg - 2'd1;
                                        enter          = (size_left_reg == 2'd1);
                                    end
                                end
                                PH_DATA:
                                begin
                                    if (c == CH_NL)
                                    begin
                                        fin = 1'b1; fin_code = STS_DONE;
                                    end
                                    else if (c == CH_END)
                                    begin
                                        fin = 1'b1; fin_code = STS_NO_NL;
                                    end
                                    else if (!c_ok)
                                    begin
                                        fin = 1'b1; fin_code = STS_BAD_DATA;
                                    end
                                    else
                                    begin
                                        bits_next      = c_off[5:0];
                                        bits_left_next = 3'd6;
                                        state_next     = S_SCAN;
                                    end
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                        OP_READ:
                        begin
                            mem_req.rd_addr = in_data.row_index;
                            state_next      = S_RDROW;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (scan_stop)
                begin
                    state_next = S_PUSH;
                end
                else if (cur_bit)
                begin
                    mem_req.rd_addr = row_reg;
                    state_next      = S_EDGE_A;
                end
                else
                begin
                    adv = 1'b1;
                end
            end
            S_EDGE_A:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = row_reg;
                mem_req.wr_data = rd_row | (64'd1 << col_reg[5:0]);
                mem_req.rd_addr = col_reg[5:0];
                state_next      = S_EDGE_B;
            end
            S_EDGE_B:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = col_reg[5:0];
                mem_req.wr_data = rd_row | (64'd1 << row_reg);
                edges_next      = edges_reg + 3'd1;
                adv             = 1'b1;
                state_next      = S_SCAN;
            end
            S_RDROW:
            begin
                rowbits_next = rd_row;
                state_next   = S_PUSH;
            end
            S_PUSH:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // step to the next upper-triangle pair
        if (adv)
        begin
            bits_left_next = bits_left_reg - 3'd1;
            if (({1'b0, row_reg} + 7'd1) == col_reg)
            begin
                row_next = '0;
                col_next = col_reg + 7'd1;
            end
            else
            begin
                row_next = row_reg + 6'd1;
            end
        end

        if (enter)
        begin
            if (count_next > 18'(MAX_VERTICES))
            begin
                fin      = 1'b1;
                fin_code = STS_TOO_MANY;
            end
            else
            begin
                col_next   = 7'd1;
                row_next   = '0;
                phase_next = PH_DATA;
            end
        end

        if (fin)
        begin
            if (phase_reg < PH_DATA)
            begin
                count_next = '0;
            end
            err_next   = fin_code;
            phase_next = PH_END;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_FIRST;
            hdr_left_reg  <= '0;
            size_left_reg <= '0;
            count_reg     <= '0;
            col_reg       <= 7'd1;
            row_reg       <= '0;
            err_reg       <= STS_BUSY;
            bits_left_reg <= '0;
            edges_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            hdr_left_reg  <= hdr_left_next;
            size_left_reg <= size_left_next;
            count_reg     <= count_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            err_reg       <= err_next;
            bits_left_reg <= bits_left_next;
            edges_reg     <= edges_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg    <= bits_next;
        rowbits_reg <= rowbits_next;
    end

    assign in_ready         = (state_reg == S_IDLE);
    assign res_valid        = (state_reg == S_PUSH);
    assign res.status       = err_reg;
    assign res.vertex_total = (phase_reg >= PH_DATA) ? count_reg[6:0] : 7'd0;
    assign res.edges_added  = edges_reg;
    assign res.row_bits     = rowbits_reg;

endmodule

`default_nettype wire

### sv/graph6_adjacency_decoder_core.sv
// Top level of the graph6 adjacency decoder: controller, row memory, output register.
// Depends on g6ad_pkg, g6ad_ctrl, g6ad_row_mem.
//
//  channel | direction | handshake          | payload
//  in      | sink      | in_valid/in_ready   | in_data  (opcode, byte_in, row_index)
//  out     | source    | out_valid/out_ready | out_data (status, vertex_total,
//          |           |                     |           edges_added, row_bits)
//
// One item at a time. Start, header/count bytes, terminators: idle, then push. Row read:
// idle, row read, push. Data byte: a scan of its bits, with two row read-modify-writes
// per edge on the single write port, then push.
// Reset clears the row table at once through per-row valid flags; start does the same.
// The output register holds a result while the next item is taken and worked on.
`default_nettype none

module graph6_adjacency_decoder_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire g6ad_pkg::in_beat_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output g6ad_pkg::out_beat_t      out_data
);
    import g6ad_pkg::*;

    mem_req_t    mem_req;
    logic [63:0] rd_row;
    logic        res_valid;
    logic        res_ready;
    out_beat_t   res;

    logic        out_valid_reg, out_valid_next;
    out_beat_t   out_data_reg;

    g6ad_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_req   (mem_req),
        .rd_row    (rd_row)
    );

    g6ad_row_mem u_row_mem (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (mem_req),
        .rd_row (rd_row)
    );

    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

### sv/g6ad_checker.sv
// Port-level checks for the graph6 adjacency decoder, bound to the top level.
// Depends on g6ad_pkg and graph6_adjacency_decoder_core_macros.svh.
`default_nettype none

`include "graph6_adjacency_decoder_core_macros.svh"

module g6ad_checker (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                in_ready,
    input  wire g6ad_pkg::in_beat_t  in_data,
    input  wire logic                out_valid,
    input  wire logic                out_ready,
    input  wire g6ad_pkg::out_beat_t out_data
);
    import g6ad_pkg::*;

    `G6AD_ASSERT_NXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_data), "in beat changed while stalled")
    `G6AD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "out beat changed while stalled")
    `G6AD_ASSERT_IMP(a_edges_busy, out_valid && (out_data.edges_added != 3'd0), (out_data.status == STS_BUSY) && (out_data.vertex_total >= 7'd2), "edges reported outside data phase")
    `G6AD_ASSERT_IMP(a_row_only_read, out_valid && (out_data.row_bits != 64'd0), out_data.edges_added == 3'd0, "row bits on a data beat")
    `G6AD_ASSERT_IMP(a_total_range, out_valid, (out_data.vertex_total <= 7'(MAX_VERTICES)) && (out_data.edges_added <= 3'd6), "vertex total or edge count out of range")

endmodule

bind graph6_adjacency_decoder_core g6ad_checker u_g6ad_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for graph6_adjacency_decoder_core: feeds graph6 strings,
// faulty strings and row reads, and checks every output beat against a model kept here.
// Depends on g6ad_pkg and the decoder RTL.

module testbench;
    import g6ad_pkg::*;

    localparam logic [1:0] OP_NOP = 2'd3;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 40;
    localparam int ITEM_TARGET = 1800;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_beat_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_beat_t out_data;

    graph6_adjacency_decoder_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    // decoder model state
    logic [63:0] adj_rows [64];
    logic [2:0]  phase;
    logic [2:0]  sts;
    int unsigned hdr_left;
    int unsigned size_left;
    int unsigned vcount;
    int unsigned col_v;
    int unsigned row_v;

    out_beat_t   pending_q [$];
    int          fail_count = 0;
    int          items_sent = 0;
    int          results_checked = 0;
    int          done_strings = 0;
    int          fault_strings = 0;
    int          burst_left = 0;
    int          idle_cycles = 0;
    int          ready_mode = 0;
    int          ready_hold = 0;
    logic [4:0]  ready_tick = '0;

    function automatic void model_clear();
        foreach (adj_rows[r])
            adj_rows[r] = '0;
        phase     = PH_FIRST;
        sts       = STS_BUSY;
        hdr_left  = 0;
        size_left = 0;
        vcount    = 0;
        col_v     = 1;
        row_v     = 0;
    endfunction

    function automatic void model_stop(logic [2:0] code);
        if (phase < PH_DATA)
            vcount = 0;
        sts   = code;
        phase = PH_END;
        if (code == STS_DONE)
            done_strings++;
        else
            fault_strings++;
    endfunction

    function automatic void model_count_done();
        if (vcount > MAX_VERTICES)
            model_stop(STS_TOO_MANY);
        else
        begin
            col_v = 1;
            row_v = 0;
            phase = PH_DATA;
        end
    endfunction

    function automatic logic [2:0] model_feed(logic [7:0] c);
        logic       in_range;
        logic [5:0] bits;
        logic [2:0] added;
        added    = '0;
        in_range = (c >= CH_LO) && (c <= CH_LONG);
        // a count character as first byte is read as the count itself
        if (phase == PH_FIRST && in_range)
            phase = PH_SIZE;
        case (phase)
            PH_FIRST:
                if (c == CH_END)
                    model_stop(STS_EMPTY);
                else if (c == CH_HDR)
                begin
                    hdr_left = HEADER_LENGTH - 1;
                    phase    = (hdr_left != 0) ? PH_HEADER : PH_SIZE;
                end
                else
                    model_stop(STS_BAD_HEAD);
            PH_HEADER:
                if (c == CH_END)
                    model_stop(STS_NO_NL);
                else
                begin
                    hdr_left--;
                    if (hdr_left == 0)
                        phase = PH_SIZE;
                end
            PH_SIZE:
                if (c == CH_END)
                    model_stop(STS_NO_NL);
                else if (!in_range)
                    model_stop(STS_BAD_HEAD);
                else if (c == CH_LONG)
                begin
                    vcount = 0;
                    phase  = PH_LONG2;
                end
                else
                begin
                    vcount = 32'(c - CH_LO);
                    model_count_done();
                end
            PH_LONG2:
                if (c == CH_END)
                    model_stop(STS_NO_NL);
                else if (c == CH_LONG)
                    model_stop(STS_TOO_MANY);
                else if (!in_range)
                    model_stop(STS_BAD_HEAD);
                else
                begin
                    vcount    = 32'(c - CH_LO);
                    size_left = 2;
                    phase     = PH_LONGREST;
                end
            PH_LONGREST:
                if (c == CH_END)
                    model_stop(STS_NO_NL);
                else if (!in_range)
                    model_stop(STS_BAD_HEAD);
                else
                begin
                    vcount = ((vcount << 6) | 32'(c - CH_LO)) & 32'h3FFFF;
                    size_left--;
                    if (size_left == 0)
                        model_count_done();
                end
            PH_DATA:
                if (c == CH_NL)
                    model_stop(STS_DONE);
                else if (c == CH_END)
                    model_stop(STS_NO_NL);
                else if (!in_range)
                    model_stop(STS_BAD_DATA);
                else
                begin
                    bits = 6'(c - CH_LO);
                    // msb first; bits past the last pair are padding
                    for (int b = 5; b >= 0 && col_v < vcount; b--)
                    begin
                        if (bits[3'(b)])
                        begin
                            adj_rows[6'(row_v)][6'(col_v)] = 1'b1;
                            adj_rows[6'(col_v)][6'(row_v)] = 1'b1;
                            added++;
                        end
                        row_v++;
                        if (row_v == col_v)
                        begin
                            row_v = 0;
                            col_v++;
                        end
                    end
                end
            default: ;
        endcase
        return added;
    endfunction

    function automatic out_beat_t decode_beat(in_beat_t beat);
        out_beat_t res;
        res = '0;
        case (beat.opcode)
            OP_START: model_clear();
            OP_FEED:  res.edges_added = model_feed(beat.byte_in);
            OP_READ:  res.row_bits = adj_rows[beat.row_index];
            default: ;
        endcase
        res.status       = sts;
        res.vertex_total = (phase >= PH_DATA) ? vcount[6:0] : 7'd0;
        return res;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // output beats are checked before the input beat of the same edge is modelled
    always @(posedge clk)
    begin : check_proc
        out_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_q.size() == 0)
            begin
                $error("output beat with no item outstanding");
                fail_count++;
            end
            else
            begin
                want = pending_q.pop_front();
                check_field("status", 64'(want.status), 64'(out_data.status));
                check_field("vertex_total", 64'(want.vertex_total),
                            64'(out_data.vertex_total));
                check_field("edges_added", 64'(want.edges_added),
                            64'(out_data.edges_added));
                check_field("row_bits", want.row_bits, out_data.row_bits);
                results_checked++;
            end
        end
        if (rst_n && in_valid && in_ready)
            pending_q.push_back(decode_beat(in_data));
    end

    always @(posedge clk)
    begin
        ready_tick <= ready_tick + 1'b1;
        if (ready_hold == 0)
        begin
            ready_mode <= $urandom_range(0, 3);
            ready_hold <= $urandom_range(50, 400);
        end
        else
            ready_hold <= ready_hold - 1;
        case (ready_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 1) == 0);
            2:       out_ready <= ($urandom_range(0, 7) != 0);
            default: out_ready <= (ready_tick >= 5'd20);
        endcase
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $error("no beat moved for %0d cycles", STALL_LIMIT);
            $display("tb: failure");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic send_beat(input logic [1:0] op, input logic [7:0] ch, input logic [5:0] idx);
        in_beat_t beat;
        int       gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 30);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        beat.opcode    = op;
        beat.byte_in   = ch;
        beat.row_index = idx;
        in_valid <= 1'b1;
        in_data  <= beat;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
    endtask

    task automatic feed(input logic [7:0] ch);
        send_beat(OP_FEED, ch, 6'($urandom_range(0, 63)));
    endtask

    task automatic start_string();
        send_beat(OP_START, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)));
    endtask

    task automatic read_row(input logic [5:0] idx);
        send_beat(OP_READ, 8'($urandom_range(0, 255)), idx);
    endtask

    task automatic send_graph(input int n, input bit with_header, input bit long_form,
                              input int density, input logic [7:0] last_ch);
        string      hdr_text;
        int         nbytes;
        logic [7:0] ch;
        logic [5:0] bits;
        hdr_text = ">>graph6<<";
        start_string();
        if (with_header)
        begin
            feed(CH_HDR);
            for (int k = 1; k < HEADER_LENGTH; k++)
            begin
                if ($urandom_range(0, 1) == 0)
                    ch = hdr_text[k];
                else
                    ch = 8'($urandom_range(1, 255));
                feed(ch);
            end
        end
        if (long_form || n > 62)
        begin
            feed(CH_LONG);
            feed(CH_LO + 8'((n >> 12) & 63));
            feed(CH_LO + 8'((n >> 6) & 63));
            feed(CH_LO + 8'(n & 63));
        end
        else
            feed(CH_LO + 8'(n));
        // past a vertex fault only a couple of ignored bytes
        nbytes = (n <= MAX_VERTICES) ? (n * (n - 1) / 2 + 5) / 6 : 2;
        for (int k = 0; k < nbytes; k++)
        begin
            for (int b = 0; b < 6; b++)
                bits[3'(b)] = ($urandom_range(0, 99) < density);
            feed(CH_LO + {2'b0, bits});
        end
        feed(last_ch);
    endtask

    task automatic test_feed_without_start();
        feed(CH_LO + 8'd2);
        feed(CH_LONG);                  // one edge, five set padding bits
        send_beat(OP_NOP, 8'hFF, 6'd63);
        feed(CH_NL);
        feed(8'h5A);                    // ignored once done
        read_row(6'd0);
        read_row(6'd1);
        read_row(6'd63);
    endtask

    task automatic test_string_faults();
        start_string();
        feed(CH_END);                   // empty string
        start_string();
        feed(8'hFF);                    // bad first byte
        start_string();
        feed(CH_HDR);
        feed(CH_END);                   // header cut short
        start_string();
        feed(CH_LONG);
        feed(CH_LONG);                  // 36-bit count
        start_string();
        feed(CH_LONG);
        feed(8'd50);                    // count byte out of range
        start_string();
        feed(CH_LONG);
        feed(CH_LO);
        feed(CH_LO + 8'd1);
        feed(CH_LO + 8'd1);             // 65 vertices
        start_string();
        feed(CH_LO + 8'd2);
        feed(CH_END);                   // string ends inside data
        start_string();
        feed(CH_LO + 8'd2);
        feed(CH_HDR);                   // data byte below 63
    endtask

    task automatic test_largest_graph();
        send_graph(MAX_VERTICES, 1'b1, 1'b1, 100, CH_NL);
        read_row(6'd0);
        read_row(6'd63);
        read_row(6'($urandom_range(0, 63)));
    endtask

    task automatic test_random_strings();
        int         kind;
        int         n;
        int         density;
        logic [7:0] ch;
        while (items_sent < ITEM_TARGET)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 70)
            begin
                kind = $urandom_range(0, 99);
                if (kind < 4)
                    n = $urandom_range(40, MAX_VERTICES);
                else if (kind < 12)
                    n = $urandom_range(0, 2);
                else
                    n = $urandom_range(3, 14);
                case ($urandom_range(0, 4))
                    0:       density = 0;
                    1:       density = 25;
                    2:       density = 50;
                    3:       density = 85;
                    default: density = 100;
                endcase
                kind = $urandom_range(0, 99);
                if (kind < 80)
                    ch = CH_NL;
                else if (kind < 86)
                    ch = CH_END;
                else if (kind < 90)
                    ch = 8'($urandom_range(1, 62));
                else if (kind < 94)
                    ch = 8'($urandom_range(127, 255));
                else
                    ch = 8'($urandom_range(63, 126));   // abandoned mid-data
                send_graph(n, $urandom_range(0, 3) == 0, $urandom_range(0, 4) == 0,
                           density, ch);
                if ($urandom_range(0, 3) == 0)
                    feed(8'($urandom_range(0, 255)));
                repeat ($urandom_range(0, 4))
                    read_row(6'($urandom_range(0, 63)));
            end
            else if (kind < 78)
            begin
                n = ($urandom_range(0, 1) == 0) ? $urandom_range(65, 80)
                                                : $urandom_range(65, 262143);
                send_graph(n, $urandom_range(0, 1) == 0, 1'b1, 50, CH_NL);
            end
            else if (kind < 92)
            begin
                if ($urandom_range(0, 4) != 0)
                    start_string();
                repeat ($urandom_range(1, 5))
                begin
                    case ($urandom_range(0, 6))
                        0:       ch = CH_END;
                        1:       ch = CH_HDR;
                        2:       ch = CH_LO;
                        3:       ch = CH_LONG;
                        4:       ch = CH_NL;
                        default: ch = 8'($urandom_range(0, 255));
                    endcase
                    feed(ch);
                end
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    send_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                              6'($urandom_range(0, 63)));
            end
        end
    endtask

    initial
    begin
        model_clear();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_feed_without_start();
        test_string_faults();
        test_largest_graph();
        test_random_strings();
        in_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("tb: %0d input beats sent, %0d output beats checked",
                 items_sent, results_checked);
        $display("tb: %0d strings decoded to the end, %0d stopped on a fault",
                 done_strings, fault_strings);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### graph6_adjacency_decoder_core.f
+incdir+sv
sv/g6ad_pkg.sv
sv/g6ad_row_mem.sv
sv/g6ad_ctrl.sv
sv/graph6_adjacency_decoder_core.sv
sv/g6ad_checker.sv
dv/testbench.sv
